### hdl/pbnc_pkg.sv
// ----------------------------------------------------------------------------
// pbnc_pkg
// Shared widths, constants and controller/datapath bundles for the palette
// blend and nearest color search block.
// ----------------------------------------------------------------------------
package pbnc_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);

  localparam int unsigned IDX_W  = 8;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned RGB_W  = 3 * CH_W;
  localparam int unsigned OP_W   = 7;
  localparam int unsigned SUM_W  = 15;
  localparam int unsigned PROD_W = 31;
  localparam int unsigned SQ_W   = 2 * CH_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  localparam logic [OP_W-1:0] PERCENT_FULL = 7'd100;

  // x / 100 == (x * RECIP_MUL) >> RECIP_SHIFT for x below 43690
  localparam int unsigned   RECIP_SHIFT = 22;
  localparam logic [15:0]   RECIP_MUL   = 16'd41944;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_USABLE  = 2'd2;

  localparam logic [OP_W-1:0]  OPACITY_RST      = 7'd100;
  localparam logic [IDX_W-1:0] FIRST_USABLE_RST = 8'd1;
  localparam logic [IDX_W-1:0] LAST_USABLE_RST  = 8'd255;

  // input item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    RD_SRC_SEL  = 2'd0,
    RD_DST_SEL  = 2'd1,
    RD_SCAN_SEL = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic            wr_en;
    logic            latch_query;
    rd_sel_e         rd_sel;
    logic            cap_src;
    logic            cap_dst;
    logic            blend_mul;
    logic            blend_div;
    logic [1:0]      chan;
    logic            scan_load;
    logic            scan_step;
    logic            scan_rd;
  } pbnc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } pbnc_sts_t;

endpackage

### hdl/pbnc_ctrl.sv
// ----------------------------------------------------------------------------
// pbnc_ctrl
// Sequencer: fetches source and destination entries, steps the blend one
// channel at a time, then walks the usable range and emits the result strobe.
// ----------------------------------------------------------------------------
module pbnc_ctrl
  import pbnc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      mode_i,
  output logic      busy,
  output logic      result_valid_o,
  output pbnc_cmd_t cmd_o,
  input  pbnc_sts_t sts_i
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD_SRC  = 4'd1;
  localparam logic [3:0] S_RD_DST  = 4'd2;
  localparam logic [3:0] S_CAP_DST = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_SCAN    = 4'd6;
  localparam logic [3:0] S_DRAIN1  = 4'd7;
  localparam logic [3:0] S_DRAIN2  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] chan_q, chan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chan_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_SRC_SEL;
    cmd_o.chan   = chan_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (mode_i == MODE_QUERY) begin
            cmd_o.latch_query = 1'b1;
            chan_d  = 2'd0;
            state_d = S_RD_SRC;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_RD_SRC: begin
        cmd_o.rd_sel = RD_SRC_SEL;
        state_d = S_RD_DST;
      end
      S_RD_DST: begin
        cmd_o.rd_sel  = RD_DST_SEL;
        cmd_o.cap_src = 1'b1;
        state_d = S_CAP_DST;
      end
      S_CAP_DST: begin
        cmd_o.cap_dst = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.blend_mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.blend_div = 1'b1;
        if (chan_q == 2'd2) begin
          cmd_o.scan_load = 1'b1;
          state_d = S_SCAN;
        end else begin
          chan_d  = chan_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_SCAN: begin
        cmd_o.rd_sel  = RD_SCAN_SEL;
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);

endmodule

### hdl/pbnc_dp.sv
// ----------------------------------------------------------------------------
// pbnc_dp
// Palette memory, per-channel blend with reciprocal divide, and the
// three-stage distance/compare pipeline of the nearest entry search.
// ----------------------------------------------------------------------------
module pbnc_dp
  import pbnc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbnc_cmd_t        cmd_i,
  output pbnc_sts_t        sts_o,
  input  logic [IDX_W-1:0] entry_index_i,
  input  logic [CH_W-1:0]  red_i,
  input  logic [CH_W-1:0]  green_i,
  input  logic [CH_W-1:0]  blue_i,
  input  logic [IDX_W-1:0] source_index_i,
  input  logic [IDX_W-1:0] dest_index_i,
  input  logic [OP_W-1:0]  opacity_i,
  input  logic [IDX_W-1:0] first_usable_i,
  input  logic [IDX_W-1:0] last_usable_i,
  output logic [IDX_W-1:0] nearest_index_o
);

  // ---------------- palette memory ----------------
  logic [RGB_W-1:0]           mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid_q;
  logic [RGB_W-1:0]           mem_rd_q;
  logic                       rd_ok_q;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_in_range, rd_in_range;
  logic [RGB_W-1:0]           rd_data;

  logic [IDX_W-1:0] src_idx_q, dst_idx_q, scan_addr_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SRC_SEL:  rd_addr = src_idx_q;
      RD_DST_SEL:  rd_addr = dst_idx_q;
      RD_SCAN_SEL: rd_addr = scan_addr_q;
      default:     rd_addr = scan_addr_q;
    endcase
  end

  assign wr_in_range = ({1'b0, entry_index_i} < (IDX_W+1)'(PALETTE_ENTRIES));
  assign rd_in_range = ({1'b0, rd_addr} < (IDX_W+1)'(PALETTE_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_in_range) begin
      mem[entry_index_i[PAL_AW-1:0]] <= {red_i, green_i, blue_i};
    end
    mem_rd_q <= mem[rd_addr[PAL_AW-1:0]];
  end

  // entries never written since reset read as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en && wr_in_range) begin
        valid_q[entry_index_i[PAL_AW-1:0]] <= 1'b1;
      end
      rd_ok_q <= rd_in_range && valid_q[rd_addr[PAL_AW-1:0]];
    end
  end

  assign rd_data = rd_ok_q ? mem_rd_q : '0;

  // ---------------- blend ----------------
  logic [RGB_W-1:0]  src_q, dst_q, tgt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [OP_W-1:0]   op_w, inv_w;
  logic [CH_W-1:0]   s_ch, d_ch, q_ch;
  logic [SUM_W-1:0]  sum_d;
  logic [PROD_W-1:0] prod;

  assign op_w  = (opacity_i > PERCENT_FULL) ? PERCENT_FULL : opacity_i;
  assign inv_w = PERCENT_FULL - op_w;

  always_comb begin
    case (cmd_i.chan)
      2'd0:    begin s_ch = src_q[CH_W-1:0];        d_ch = dst_q[CH_W-1:0];        end
      2'd1:    begin s_ch = src_q[2*CH_W-1:CH_W];   d_ch = dst_q[2*CH_W-1:CH_W];   end
      default: begin s_ch = src_q[3*CH_W-1:2*CH_W]; d_ch = dst_q[3*CH_W-1:2*CH_W]; end
    endcase
  end

  assign sum_d = SUM_W'(s_ch) * SUM_W'(op_w) + SUM_W'(d_ch) * SUM_W'(inv_w);
  assign prod  = PROD_W'(sum_q) * PROD_W'(RECIP_MUL);
  assign q_ch  = prod[RECIP_SHIFT +: CH_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_query) begin
      src_idx_q <= source_index_i;
      dst_idx_q <= dest_index_i;
    end
    if (cmd_i.cap_src)   src_q <= rd_data;
    if (cmd_i.cap_dst)   dst_q <= rd_data;
    if (cmd_i.blend_mul) sum_q <= sum_d;
    if (cmd_i.blend_div) begin
      case (cmd_i.chan)
        2'd0:    tgt_q[CH_W-1:0]        <= q_ch;
        2'd1:    tgt_q[2*CH_W-1:CH_W]   <= q_ch;
        default: tgt_q[3*CH_W-1:2*CH_W] <= q_ch;
      endcase
    end
  end

  // ---------------- search ----------------
  logic [IDX_W-1:0] scan_end;
  logic             s1_v_q, s2_v_q, first_q;
  logic [IDX_W-1:0] s1_idx_q, s2_idx_q, best_q;
  logic [SQ_W-1:0]  sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0] dist_sum, best_d_q;
  logic [CH_W-1:0]  dr, dg, db;

  // empty range degenerates to a single look at first_usable
  assign scan_end = (first_usable_i > last_usable_i) ? first_usable_i : last_usable_i;
  assign sts_o.scan_last = (scan_addr_q == scan_end);

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign dr = abs_diff(rd_data[3*CH_W-1:2*CH_W], tgt_q[3*CH_W-1:2*CH_W]);
  assign dg = abs_diff(rd_data[2*CH_W-1:CH_W],   tgt_q[2*CH_W-1:CH_W]);
  assign db = abs_diff(rd_data[CH_W-1:0],        tgt_q[CH_W-1:0]);

  assign dist_sum = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_load) begin
      scan_addr_q <= first_usable_i;
    end else if (cmd_i.scan_step) begin
      scan_addr_q <= scan_addr_q + IDX_W'(1);
    end
    s1_idx_q <= scan_addr_q;
    s2_idx_q <= s1_idx_q;
    sq_r_q   <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_q   <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_q   <= SQ_W'(db) * SQ_W'(db);
    if (s2_v_q && (first_q || (dist_sum < best_d_q))) begin
      best_d_q <= dist_sum;
      best_q   <= s2_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      first_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.scan_rd;
      s2_v_q <= s1_v_q;
      if (cmd_i.scan_load) begin
        first_q <= 1'b1;
      end else if (s2_v_q) begin
        first_q <= 1'b0;
      end
    end
  end

  assign nearest_index_o = best_q;

endmodule

### hdl/palette_blend_nearest_color.sv
// ----------------------------------------------------------------------------
// palette_blend_nearest_color
// Palette of RGB entries with percent-opacity blend and nearest entry search.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken when start is high and busy is low. mode_i = 0
//   writes red/green/blue into entry entry_index_i in that cycle; busy stays
//   low and no result follows. mode_i = 1 blends entry source_index_i over
//   dest_index_i at the opacity register, then searches first_usable ..
//   last_usable for the least squared RGB distance (lower index wins ties).
//   A query holds busy through fetch states S_RD_SRC, S_RD_DST, S_CAP_DST,
//   a multiply and a divide step per blend channel, and a scan of N palette
//   entries, N = last_usable - first_usable + 1 (1 when the range is empty),
//   one per cycle through the memory's single read port, then the search
//   pipeline. The result beat is nearest_index_o with result_valid_o high
//   for one cycle; there is no backpressure, the receiver must take it.
//   Configuration writes (cfg_ready_o always high) are to go in while idle; unenforced by the block.
//   Reset: palette reads black, opacity 100, first_usable 1, last_usable 255.
// ----------------------------------------------------------------------------
module palette_blend_nearest_color
  import pbnc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  input  logic [CH_W-1:0]      red_i,
  input  logic [CH_W-1:0]      green_i,
  input  logic [CH_W-1:0]      blue_i,
  input  logic [IDX_W-1:0]     source_index_i,
  input  logic [IDX_W-1:0]     dest_index_i,
  output logic                 result_valid_o,
  output logic [IDX_W-1:0]     nearest_index_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [IDX_W-1:0]     cfg_data_i
);

  logic [OP_W-1:0]  opacity_q;
  logic [IDX_W-1:0] first_usable_q, last_usable_q;
  pbnc_cmd_t        cmd;
  pbnc_sts_t        sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q      <= OPACITY_RST;
      first_usable_q <= FIRST_USABLE_RST;
      last_usable_q  <= LAST_USABLE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OPACITY:      opacity_q      <= cfg_data_i[OP_W-1:0];
        CFG_FIRST_USABLE: first_usable_q <= cfg_data_i;
        CFG_LAST_USABLE:  last_usable_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pbnc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .mode_i         (mode_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  pbnc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .source_index_i  (source_index_i),
    .dest_index_i    (dest_index_i),
    .opacity_i       (opacity_q),
    .first_usable_i  (first_usable_q),
    .last_usable_i   (last_usable_q),
    .nearest_index_o (nearest_index_o)
  );

endmodule

### sim/palette_blend_nearest_color_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_blend_nearest_color_tb
// Self-checking bench for the palette blend and nearest color search. Palette
// writes and blend queries go through a gapped command driver. A local mirror
// of the palette and the registers predicts each nearest index, and a monitor
// checks every result strobe against it. Register settings change between
// phases while the block is quiet.
// ----------------------------------------------------------------------------
module palette_blend_nearest_color_tb;
  import pbnc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned QUIET_CYCLES   = 16;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS    = 63;

  typedef struct {
    logic             mode;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [IDX_W-1:0] source_index;
    logic [IDX_W-1:0] dest_index;
  } palette_op_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 mode = MODE_WRITE;
  logic [IDX_W-1:0]     entry_index = '0;
  logic [CH_W-1:0]      red = '0;
  logic [CH_W-1:0]      green = '0;
  logic [CH_W-1:0]      blue = '0;
  logic [IDX_W-1:0]     source_index = '0;
  logic [IDX_W-1:0]     dest_index = '0;
  logic                 result_valid;
  logic [IDX_W-1:0]     nearest_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0]     cfg_data = '0;

  // mirror of the block's state
  logic [RGB_W-1:0] palette_mirror [PALETTE_ENTRIES];
  logic [OP_W-1:0]  opacity_cfg = OPACITY_RST;
  logic [IDX_W-1:0] first_cfg   = FIRST_USABLE_RST;
  logic [IDX_W-1:0] last_cfg    = LAST_USABLE_RST;

  palette_op_t      pending_ops[$];
  logic [IDX_W-1:0] nearest_expected[$];
  palette_op_t      cur_op;
  int unsigned      gap_left = 0;
  bit               no_idle = 1'b0;
  int unsigned      mismatch_count = 0;
  int unsigned      idle_cycles = 0;
  logic [RGB_W-1:0] color_pool[$];

  palette_blend_nearest_color dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode),
    .entry_index_i   (entry_index),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .source_index_i  (source_index),
    .dest_index_i    (dest_index),
    .result_valid_o  (result_valid),
    .nearest_index_o (nearest_index),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < PALETTE_ENTRIES; i++) palette_mirror[i] = '0;
  end

  // blend source over destination, then scan the usable range
  function automatic logic [IDX_W-1:0] predict_nearest(logic [IDX_W-1:0] src_idx,
                                                        logic [IDX_W-1:0] dst_idx);
    int unsigned op, full, s, d, diff, dist_sq, best, best_dist;
    int unsigned target [3];
    int          i;
    full = 32'(PERCENT_FULL);
    op = (opacity_cfg > PERCENT_FULL) ? full : 32'(opacity_cfg);
    for (int c = 0; c < 3; c++) begin
      s = 32'(palette_mirror[src_idx][8*c +: 8]);
      d = 32'(palette_mirror[dst_idx][8*c +: 8]);
      target[c] = (s * op + d * (full - op)) / full;
    end
    best = 32'(first_cfg);
    best_dist = 32'hFFFF_FFFF;
    for (i = int'(first_cfg); i <= int'(last_cfg) || i == int'(first_cfg); i++) begin
      dist_sq = 0;
      for (int c = 0; c < 3; c++) begin
        s = 32'(palette_mirror[i][8*c +: 8]);
        diff = (s > target[c]) ? s - target[c] : target[c] - s;
        dist_sq += diff * diff;
      end
      // strict compare keeps the lower index on ties
      if (dist_sq < best_dist) begin
        best_dist = dist_sq;
        best = 32'(i);
      end
    end
    return best[IDX_W-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic palette_op_t make_write(logic [IDX_W-1:0] idx, logic [RGB_W-1:0] rgb);
    palette_op_t op;
    op.mode         = MODE_WRITE;
    op.entry_index  = idx;
    {op.red, op.green, op.blue} = rgb;
    op.source_index = IDX_W'($urandom_range(0, 255));
    op.dest_index   = IDX_W'($urandom_range(0, 255));
    return op;
  endfunction

  function automatic palette_op_t make_query(logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst);
    palette_op_t op;
    op.mode         = MODE_QUERY;
    op.entry_index  = IDX_W'($urandom_range(0, 255));
    op.red          = CH_W'($urandom_range(0, 255));
    op.green        = CH_W'($urandom_range(0, 255));
    op.blue         = CH_W'($urandom_range(0, 255));
    op.source_index = src;
    op.dest_index   = dst;
    return op;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      if (cur_op.mode == MODE_WRITE) begin
        palette_mirror[cur_op.entry_index] = {cur_op.red, cur_op.green, cur_op.blue};
      end else begin
        nearest_expected.push_back(predict_nearest(cur_op.source_index, cur_op.dest_index));
      end
      gap_left = pick_gap();
      if (gap_left == 0 && pending_ops.size() != 0) begin
        cur_op = pending_ops.pop_front();
        mode         <= cur_op.mode;
        entry_index  <= cur_op.entry_index;
        red          <= cur_op.red;
        green        <= cur_op.green;
        blue         <= cur_op.blue;
        source_index <= cur_op.source_index;
        dest_index   <= cur_op.dest_index;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() != 0) begin
        cur_op = pending_ops.pop_front();
        mode         <= cur_op.mode;
        entry_index  <= cur_op.entry_index;
        red          <= cur_op.red;
        green        <= cur_op.green;
        blue         <= cur_op.blue;
        source_index <= cur_op.source_index;
        dest_index   <= cur_op.dest_index;
        start        <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    logic [IDX_W-1:0] want;
    if (rst_ni && result_valid) begin
      if (nearest_expected.size() == 0) begin
        $error("nearest_index: expected none, actual %0d", nearest_index);
        mismatch_count++;
      end else begin
        want = nearest_expected.pop_front();
        if (nearest_index !== want) begin
          $error("nearest_index: expected %0d, actual %0d", want, nearest_index);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [IDX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_OPACITY:      opacity_cfg = data[OP_W-1:0];
      CFG_FIRST_USABLE: first_cfg   = data;
      CFG_LAST_USABLE:  last_cfg    = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [IDX_W-1:0] op_data, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi);
    write_register(CFG_OPACITY, op_data);
    write_register(CFG_FIRST_USABLE, lo);
    write_register(CFG_LAST_USABLE, hi);
    cfg_valid <= 1'b0;
  endtask

  // drain everything, then let the scan pipeline settle; sample mid-cycle so
  // the driver's updates from the last edge are seen
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (start || busy || pending_ops.size() != 0 || nearest_expected.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [RGB_W-1:0] pick_color();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 24'h000000;
    if (roll < 18) return 24'hFFFFFF;
    // reused colors give distance ties
    if (roll < 35 && color_pool.size() != 0)
      return color_pool[$urandom_range(0, color_pool.size() - 1)];
    return RGB_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  task automatic fill_random_phase();
    logic [RGB_W-1:0] rgb;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 45) begin
        rgb = pick_color();
        color_pool.push_back(rgb);
        pending_ops.push_back(make_write(IDX_W'($urandom_range(0, 255)), rgb));
      end else begin
        pending_ops.push_back(make_query(IDX_W'($urandom_range(0, 255)),
                                         IDX_W'($urandom_range(0, 255))));
      end
    end
  endtask

  initial begin : stimulus
    logic [IDX_W-1:0] op_data, lo, hi;
    int unsigned      roll;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: all black, tie goes to the lowest usable index
    no_idle = 1'b1;
    pending_ops.push_back(make_query(8'd0, 8'd0));
    pending_ops.push_back(make_write(8'd0, 24'hFFFFFF));
    pending_ops.push_back(make_write(8'd255, 24'hFFFFFF));
    pending_ops.push_back(make_write(8'd1, 24'h000000));
    pending_ops.push_back(make_write(8'd128, 24'hFF0000));
    pending_ops.push_back(make_write(8'd2, 24'h00FF00));
    pending_ops.push_back(make_write(8'd3, 24'h0000FF));
    pending_ops.push_back(make_query(8'd0, 8'd255));
    pending_ops.push_back(make_query(8'd128, 8'd3));
    pending_ops.push_back(make_query(8'd2, 8'd3));
    wait_quiet();

    // destination only, full range
    configure(8'd0, 8'd0, 8'd255);
    no_idle = 1'b0;
    pending_ops.push_back(make_query(8'd0, 8'd128));
    pending_ops.push_back(make_query(8'd255, 8'd2));
    pending_ops.push_back(make_query(8'd3, 8'd0));
    wait_quiet();

    // top bit of the opacity data is dropped; single entry range at the top
    configure(8'hE4, 8'd255, 8'd255);
    pending_ops.push_back(make_query(8'd2, 8'd3));
    pending_ops.push_back(make_write(8'd255, 24'h123456));
    pending_ops.push_back(make_query(8'd128, 8'd0));
    wait_quiet();

    // empty range answers first_usable
    configure(8'd50, 8'd200, 8'd10);
    pending_ops.push_back(make_query(8'd0, 8'd1));
    pending_ops.push_back(make_query(8'd128, 8'd2));
    wait_quiet();

    // opacity above full acts as source only; bottom single entry
    configure(8'd127, 8'd0, 8'd0);
    pending_ops.push_back(make_query(8'd128, 8'd2));
    wait_quiet();
    configure(8'd101, 8'd0, 8'd3);
    pending_ops.push_back(make_query(8'd128, 8'd2));
    pending_ops.push_back(make_query(8'd0, 8'd3));
    wait_quiet();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      roll = $urandom_range(0, 99);
      op_data = (roll < 15) ? IDX_W'($urandom_range(101, 127))
                            : IDX_W'($urandom_range(0, 100));
      op_data[OP_W] = 1'($urandom_range(0, 1));
      lo = ($urandom_range(0, 99) < 60) ? IDX_W'($urandom_range(0, 16))
                                        : IDX_W'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 70) hi = IDX_W'($urandom_range(lo, 255));
      else if (roll < 85) hi = IDX_W'($urandom_range(0, 255));
      else hi = 8'd255;
      configure(op_data, lo, hi);
      no_idle = (p == 1);
      fill_random_phase();
      wait_quiet();
    end

    if (mismatch_count == 0 && nearest_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
